### hdl/turn_speed_profiler_unit_assert.svh
// ----------------------------------------------------------------------------
// turn speed profiler assertion macros
// concurrent property wrappers clocked on i_clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef TURN_SPEED_PROFILER_UNIT_ASSERT_SVH
`define TURN_SPEED_PROFILER_UNIT_ASSERT_SVH

// same-cycle implication
`define TSP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("tsp assertion failed");

// next-cycle implication
`define TSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("tsp assertion failed");

`endif

### hdl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// shared types and constants of the turn speed profiler
// ----------------------------------------------------------------------------
package tsp_pkg;

    // pi/4 in Q0.16, converts binary angle to Q3.13 radians
    localparam logic [15:0] PI_QUARTER_Q16 = 16'd51472;

    localparam logic [15:0] MIN_SPEED_RST  = 16'd768;
    localparam logic [14:0] STOP_THRESH_RST = 15'd5215;

    localparam int RADICAND_W = 28;
    localparam int ROOT_W     = RADICAND_W / 2;
    localparam int ADDR_W     = 5;

    typedef enum logic [2:0] {
        REG_TARGET    = 3'd0,
        REG_MAX_VEL   = 3'd1,
        REG_ACCEL_LIM = 3'd2,
        REG_MIN_SPEED = 3'd3,
        REG_STOP_THR  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] target_angle;
        logic [15:0] cruise_speed;
        logic [15:0] accel_limit;
        logic [15:0] min_speed;
        logic [14:0] stop_threshold;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_root_stat;

endpackage

### hdl/tsp_regs.sv
// ----------------------------------------------------------------------------
// tsp_regs
// apb configuration registers of the turn speed profiler
// ----------------------------------------------------------------------------
module tsp_regs import tsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_angle   <= '0;
            r_cfg.cruise_speed   <= '0;
            r_cfg.accel_limit    <= '0;
            r_cfg.min_speed      <= MIN_SPEED_RST;
            r_cfg.stop_threshold <= STOP_THRESH_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_TARGET:    r_cfg.target_angle   <= pwdata[15:0];
                REG_MAX_VEL:   r_cfg.cruise_speed   <= pwdata[15:0];
                REG_ACCEL_LIM: r_cfg.accel_limit    <= pwdata[15:0];
                REG_MIN_SPEED: r_cfg.min_speed      <= pwdata[15:0];
                REG_STOP_THR:  r_cfg.stop_threshold <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TARGET:    prdata = {16'd0, r_cfg.target_angle};
            REG_MAX_VEL:   prdata = {16'd0, r_cfg.cruise_speed};
            REG_ACCEL_LIM: prdata = {16'd0, r_cfg.accel_limit};
            REG_MIN_SPEED: prdata = {16'd0, r_cfg.min_speed};
            REG_STOP_THR:  prdata = {17'd0, r_cfg.stop_threshold};
            default:       prdata = '0;
        endcase
    end

endmodule

### hdl/tsp_isqrt.sv
// ----------------------------------------------------------------------------
// tsp_isqrt
// bit-serial floor square root, one root bit per cycle
// ----------------------------------------------------------------------------
module tsp_isqrt import tsp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [RADICAND_W-1:0] i_radicand,
    output logic [ROOT_W-1:0]     o_root,
    output t_root_stat            o_stat
);

    localparam int REM_W = ROOT_W + 1;
    localparam int CNT_W = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_W - 1);

    logic [RADICAND_W-1:0] r_rad;
    logic [REM_W-1:0]      r_rem;
    logic [ROOT_W-1:0]     r_root;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [REM_W+1:0] w_rem_sh;
    logic [REM_W+1:0] w_trial;
    logic             w_fit;

    assign w_rem_sh = {r_rem, r_rad[RADICAND_W-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_fit    = w_rem_sh >= w_trial;

    assign o_root      = r_root;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[RADICAND_W-3:0], 2'b00};
            if (w_fit) begin
                // remainder stays below 2*root+1, so the top bits drop
                r_rem  <= REM_W'(w_rem_sh - w_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(w_rem_sh);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

### hdl/turn_speed_profiler_unit.sv
// ----------------------------------------------------------------------------
// turn_speed_profiler_unit
// trapezoidal speed profile for an in-place turn toward a goal heading
// ----------------------------------------------------------------------------
// Each accepted item (elapsed time, heading) yields one result (drive command,
// done flag), and the input stays stalled until the result is handed to the
// output register, so a new item is not taken before the previous one is
// through. The work is done by one shared 16x16 multiplier used for three
// products in turn, followed by a 14-step bit-serial square root that
// produces the stopping-distance speed cap. The output register lets a new
// item enter while the previous result still waits downstream.
`include "turn_speed_profiler_unit_assert.svh"

module turn_speed_profiler_unit import tsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // apb configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input items
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [9:0]        i_elapsed,
    input  logic signed [15:0] i_heading,
    // result items
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic signed [16:0] o_drive_command,
    output logic              o_done_res
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_MUL_INC   = 7'b0000010,
        S_MUL_RAD   = 7'b0000100,
        S_MUL_CAP   = 7'b0001000,
        S_ROOT_GO   = 7'b0010000,
        S_ROOT_WAIT = 7'b0100000,
        S_OUT       = 7'b1000000
    } t_state;

    t_cfg       w_cfg;
    t_root_stat w_root_stat;
    logic [ROOT_W-1:0] w_root;

    t_state r_state, n_state;

    logic [9:0]  r_elapsed;
    logic [15:0] r_mag;
    logic        r_pos;
    logic        r_fin;
    logic [31:0] r_prod;
    logic [15:0] r_inc;
    logic [15:0] r_speed;
    logic [15:0] r_last_speed;
    logic        r_out_valid;
    logic [16:0] r_drive;
    logic        r_done;

    logic        w_in_acc;
    logic        w_out_free;
    logic [15:0] w_rem;
    logic [15:0] w_mag;
    logic [15:0] w_mul_a;
    logic [15:0] w_mul_b;
    logic [16:0] w_up;
    logic [16:0] w_down;
    logic [15:0] w_speed_rl;
    logic [15:0] w_cap;
    logic [15:0] w_capped;
    logic [15:0] w_final;
    logic [16:0] w_drive;

    tsp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tsp_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_ROOT_GO),
        .i_radicand ({1'b0, r_prod[30:4]}),
        .o_root     (w_root),
        .o_stat     (w_root_stat)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_drive_command = r_drive;
    assign o_done_res  = r_done;

    // wrapped remaining angle and its magnitude, half turn reads as 32768
    assign w_rem = w_cfg.target_angle - i_heading;
    assign w_mag = w_rem[15] ? (~w_rem + 16'd1) : w_rem;

    // shared multiplier operand selection
    always_comb begin
        unique case (r_state)
            S_MUL_INC: begin
                w_mul_a = {6'd0, r_elapsed};
                w_mul_b = w_cfg.accel_limit;
            end
            S_MUL_RAD: begin
                w_mul_a = r_mag;
                w_mul_b = PI_QUARTER_Q16;
            end
            S_MUL_CAP: begin
                w_mul_a = r_prod[31:16];
                w_mul_b = w_cfg.accel_limit;
            end
            default: begin
                w_mul_a = r_mag;
                w_mul_b = w_cfg.accel_limit;
            end
        endcase
    end

    // rate limit toward cruise speed, result lies between last and target
    assign w_up   = {1'b0, r_last_speed} + {1'b0, r_inc};
    assign w_down = {1'b0, r_last_speed} - {1'b0, r_inc};
    always_comb begin
        priority if ({1'b0, w_cfg.cruise_speed} > w_up) begin
            w_speed_rl = w_up[15:0];
        end else if (r_last_speed >= r_inc && {1'b0, w_cfg.cruise_speed} < w_down) begin
            w_speed_rl = w_down[15:0];
        end else begin
            w_speed_rl = w_cfg.cruise_speed;
        end
    end

    assign w_cap    = {{(16-ROOT_W){1'b0}}, w_root};
    assign w_capped = (r_speed > w_cap) ? w_cap : r_speed;
    assign w_final  = (w_capped < w_cfg.min_speed) ? w_cfg.min_speed : w_capped;
    assign w_drive  = r_fin ? 17'd0 :
                      r_pos ? (17'd0 - {1'b0, w_final}) : {1'b0, w_final};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (w_in_acc) n_state = S_MUL_INC;
            S_MUL_INC:   n_state = S_MUL_RAD;
            S_MUL_RAD:   n_state = S_MUL_CAP;
            S_MUL_CAP:   n_state = S_ROOT_GO;
            S_ROOT_GO:   n_state = S_ROOT_WAIT;
            S_ROOT_WAIT: if (w_root_stat.done) n_state = S_OUT;
            S_OUT:       if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_speed <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free) begin
                r_last_speed <= w_final;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_elapsed <= i_elapsed;
            r_mag     <= w_mag;
            r_pos     <= !w_rem[15] && (w_rem != 16'd0);
            r_fin     <= w_mag < {1'b0, w_cfg.stop_threshold};
        end
        if (r_state == S_MUL_INC || r_state == S_MUL_RAD || r_state == S_MUL_CAP) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (r_state == S_MUL_RAD) begin
            r_inc <= r_prod[25:10];
        end
        if (r_state == S_MUL_CAP) begin
            r_speed <= w_speed_rl;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_drive <= w_drive;
            r_done  <= r_fin;
        end
    end

    `TSP_ASSERT_IMP(a_done_zero_drive, o_out_valid && o_done_res, o_drive_command == 17'd0)
    `TSP_ASSERT_NEXT(a_accept_starts, w_in_acc, r_state == S_MUL_INC)
    `TSP_ASSERT_NEXT(a_last_only_out, r_state != S_OUT, $stable(r_last_speed))
    `TSP_ASSERT_IMP(a_root_in_wait, w_root_stat.done, r_state == S_ROOT_WAIT)

endmodule
